[hw/rtl/epsm_pkg.sv]
// ---------------------------------------------------------------------------
// Encoder period speed meter package
// Shared types, request codes and widths for the speed meter modules.
// ---------------------------------------------------------------------------
package epsm_pkg;

    localparam int PERIOD_W = 32;
    localparam int COEF_W   = 16;
    localparam int FRAC_W   = 16;
    localparam int FILT_W   = PERIOD_W + FRAC_W;
    localparam int SPEED_W  = 40;
    localparam int OUT_W    = SPEED_W + PERIOD_W + PERIOD_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Shared divider: dividend as wide as the speed numerator.
    localparam int DIV_W     = SPEED_W;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_COEF   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RPM_SCALE     = 2'd2;

    localparam logic              RST_FILTER_ENABLE = 1'b1;
    localparam logic [COEF_W-1:0] RST_FILTER_COEF   = 16'd6554;
    localparam logic [PERIOD_W-1:0] RST_RPM_SCALE   = 32'd60000000;

    typedef enum logic [1:0] {
        REQ_CAPTURE = 2'd0,
        REQ_READ    = 2'd1,
        REQ_SWAP    = 2'd2,
        REQ_CLEAR   = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        MUL_NONE = 2'd0,
        MUL_AVG  = 2'd1,
        MUL_HIGH = 2'd2,
        MUL_LOW  = 2'd3
    } t_mul_step;

    typedef enum logic {
        DIV_AVG   = 1'b0,
        DIV_SPEED = 1'b1
    } t_div_sel;

    typedef struct packed {
        logic      take;
        logic      div_start;
        t_div_sel  div_sel;
        logic      avg_load;
        t_mul_step mul_step;
        logic      filt_load;
        logic      out_load;
    } t_cmd;

    typedef struct packed {
        logic req_read;
        logic div_busy;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

[hw/rtl/epsm_div.sv]
// ---------------------------------------------------------------------------
// Encoder period speed meter divider
// Restoring divider, one quotient bit per cycle, shared by average and speed.
// ---------------------------------------------------------------------------
module epsm_div
    import epsm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [DIV_W-1:0]    i_dividend,
    input  logic [PERIOD_W-1:0] i_divisor,
    output logic                o_busy,
    output logic                o_done,
    output logic [DIV_W-1:0]    o_quotient
);

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [PERIOD_W-1:0]  r_rem, n_rem;
    logic [DIV_W-1:0]     r_quo, n_quo;
    logic [PERIOD_W:0]    w_shift;
    logic [PERIOD_W:0]    w_trial;

    assign w_shift = {r_rem, r_quo[DIV_W-1]};
    assign w_trial = w_shift - {1'b0, i_divisor};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = DIV_CNT_W'(DIV_W);
            n_rem  = '0;
            n_quo  = i_dividend;
        end else if (r_busy) begin
            // A borrow out of the trial subtraction means the divisor did not fit.
            if (!w_trial[PERIOD_W]) begin
                n_rem = w_trial[PERIOD_W-1:0];
                n_quo = {r_quo[DIV_W-2:0], 1'b1};
            end else begin
                n_rem = w_shift[PERIOD_W-1:0];
                n_quo = {r_quo[DIV_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == DIV_CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

[hw/rtl/epsm_datapath.sv]
// ---------------------------------------------------------------------------
// Encoder period speed meter datapath
// Period banks, configuration registers, IIR filter, divider and result register.
// ---------------------------------------------------------------------------
module epsm_datapath
    import epsm_pkg::*;
#(
    parameter int PULSE_SLOTS = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    input  logic [1:0]            i_s_tuser,
    input  logic [PERIOD_W-1:0]   i_s_tdata,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_W-1:0]      o_m_tdata
);

    localparam int CW = $clog2(PULSE_SLOTS);
    localparam logic [CW:0] SLOTS = (CW + 1)'(PULSE_SLOTS);

    logic                r_filter_en;
    logic [COEF_W-1:0]   r_coef;
    logic [PERIOD_W-1:0] r_rpm;

    logic                r_active;
    logic [PERIOD_W-1:0] r_sum [2];
    logic [CW-1:0]       r_cnt [2];
    logic [FILT_W-1:0]   r_filt;

    logic [PERIOD_W-1:0] r_rsum;
    logic [CW-1:0]       r_rcnt;
    logic [PERIOD_W-1:0] r_avg;
    logic [FILT_W-1:0]   r_prod;
    logic [FILT_W-1:0]   r_acc;

    logic                r_out_valid;
    logic [OUT_W-1:0]    r_out_data;

    t_req                w_req;
    logic                w_bank;
    logic [CW:0]         w_cnt_inc;
    logic [COEF_W-1:0]   w_mul_a;
    logic [PERIOD_W-1:0] w_mul_b;
    logic [FILT_W-1:0]   w_filt_next;
    logic [PERIOD_W-1:0] w_fcount;
    logic [DIV_W-1:0]    w_dividend;
    logic [PERIOD_W-1:0] w_divisor;
    logic [DIV_W-1:0]    w_quo;
    logic                w_div_busy;
    logic                w_div_done;
    logic [SPEED_W-1:0]  w_speed;

    assign w_req     = t_req'(i_s_tuser);
    // Captures go to the active bank, reads take the other one.
    assign w_bank    = (w_req == REQ_CAPTURE) ? r_active : ~r_active;
    assign w_cnt_inc = {1'b0, r_cnt[w_bank]} + 1'b1;
    assign w_fcount  = r_filt[FILT_W-1:FRAC_W];

    // The weight of the old value, 65536 - c, fits 16 bits whenever c is non-zero.
    always_comb begin
        case (i_cmd.mul_step)
            MUL_AVG: begin
                w_mul_a = r_coef;
                w_mul_b = r_avg;
            end
            MUL_HIGH: begin
                w_mul_a = COEF_W'(0) - r_coef;
                w_mul_b = r_filt[FILT_W-1:FRAC_W];
            end
            MUL_LOW: begin
                w_mul_a = COEF_W'(0) - r_coef;
                w_mul_b = {{(PERIOD_W-FRAC_W){1'b0}}, r_filt[FRAC_W-1:0]};
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    always_comb begin
        if (!r_filter_en) begin
            w_filt_next = {r_avg, {FRAC_W{1'b0}}};
        end else if (r_coef == '0) begin
            w_filt_next = r_filt;
        end else begin
            w_filt_next = r_acc + {{FRAC_W{1'b0}}, r_prod[FILT_W-1:FRAC_W]};
        end
    end

    assign w_dividend = (i_cmd.div_sel == DIV_AVG) ? DIV_W'(r_rsum) : {r_rpm, 8'd0};
    assign w_divisor  = (i_cmd.div_sel == DIV_AVG) ? PERIOD_W'(r_rcnt) : w_fcount;
    assign w_speed    = (w_fcount == '0) ? '0 : w_quo;

    epsm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_en <= RST_FILTER_ENABLE;
            r_coef      <= RST_FILTER_COEF;
            r_rpm       <= RST_RPM_SCALE;
            r_active    <= 1'b0;
            r_sum[0]    <= '0;
            r_sum[1]    <= '0;
            r_cnt[0]    <= '0;
            r_cnt[1]    <= '0;
            r_filt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_FILTER_ENABLE: r_filter_en <= i_cfg_data[0];
                    CFG_FILTER_COEF:   r_coef      <= i_cfg_data[COEF_W-1:0];
                    CFG_RPM_SCALE:     r_rpm       <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.take) begin
                case (w_req)
                    REQ_CAPTURE: begin
                        // Reaching the slot limit discards the bank, new pulse included.
                        if (w_cnt_inc == SLOTS) begin
                            r_sum[w_bank] <= '0;
                            r_cnt[w_bank] <= '0;
                        end else begin
                            r_sum[w_bank] <= r_sum[w_bank] + i_s_tdata;
                            r_cnt[w_bank] <= w_cnt_inc[CW-1:0];
                        end
                    end
                    REQ_READ: begin
                        r_sum[w_bank] <= '0;
                        r_cnt[w_bank] <= '0;
                    end
                    REQ_SWAP: r_active <= ~r_active;
                    REQ_CLEAR: begin
                        r_active <= 1'b0;
                        r_sum[0] <= '0;
                        r_sum[1] <= '0;
                        r_cnt[0] <= '0;
                        r_cnt[1] <= '0;
                    end
                    default: ;
                endcase
            end
            if (i_cmd.filt_load) begin
                r_filt <= w_filt_next;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_rsum <= r_sum[w_bank];
            r_rcnt <= r_cnt[w_bank];
        end
        if (i_cmd.avg_load) begin
            r_avg <= (r_rcnt == '0) ? '0 : w_quo[PERIOD_W-1:0];
        end
        if (i_cmd.mul_step != MUL_NONE) begin
            r_prod <= {{PERIOD_W{1'b0}}, w_mul_a} * {{FRAC_W{1'b0}}, w_mul_b};
        end
        if (i_cmd.mul_step == MUL_HIGH) begin
            r_acc <= r_prod;
        end else if (i_cmd.mul_step == MUL_LOW) begin
            r_acc <= r_acc + r_prod;
        end
        if (i_cmd.out_load) begin
            r_out_data <= {r_avg, w_fcount, w_speed};
        end
    end

    assign o_sts.req_read = (w_req == REQ_READ);
    assign o_sts.div_busy = w_div_busy;
    assign o_sts.div_done = w_div_done;
    assign o_sts.out_free = !r_out_valid || i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

`ifndef NO_ASSERTIONS
    a_cnt_below_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_cnt[0]} < SLOTS) && ({1'b0, r_cnt[1]} < SLOTS))
        else $error("bank count reached the slot limit");
    a_filt_not_moved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.filt_load && !i_cmd.take |=> $stable(r_filt) && $stable(r_active))
        else $error("filter or bank select changed without a command");
`endif

endmodule

[hw/rtl/epsm_ctrl.sv]
// ---------------------------------------------------------------------------
// Encoder period speed meter controller
// Sequences a speed read: average division, filter multiplies, speed division.
// ---------------------------------------------------------------------------
module epsm_ctrl
    import epsm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [9:0] {
        S_IDLE     = 10'b00_0000_0001,
        S_AVG_GO   = 10'b00_0000_0010,
        S_AVG_WAIT = 10'b00_0000_0100,
        S_MUL_AVG  = 10'b00_0000_1000,
        S_MUL_HIGH = 10'b00_0001_0000,
        S_MUL_LOW  = 10'b00_0010_0000,
        S_FILT     = 10'b00_0100_0000,
        S_SPD_GO   = 10'b00_1000_0000,
        S_SPD_WAIT = 10'b01_0000_0000,
        S_DONE     = 10'b10_0000_0000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        o_cmd.div_sel   = DIV_AVG;
        o_cmd.mul_step  = MUL_NONE;
        o_s_tready      = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.take = 1'b1;
                    if (i_sts.req_read) begin
                        n_state = S_AVG_GO;
                    end
                end
            end
            S_AVG_GO: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_AVG_WAIT;
            end
            S_AVG_WAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.avg_load = 1'b1;
                    n_state        = S_MUL_AVG;
                end
            end
            S_MUL_AVG: begin
                o_cmd.mul_step = MUL_AVG;
                n_state        = S_MUL_HIGH;
            end
            S_MUL_HIGH: begin
                o_cmd.mul_step = MUL_HIGH;
                n_state        = S_MUL_LOW;
            end
            S_MUL_LOW: begin
                o_cmd.mul_step = MUL_LOW;
                n_state        = S_FILT;
            end
            S_FILT: begin
                o_cmd.filt_load = 1'b1;
                n_state         = S_SPD_GO;
            end
            S_SPD_GO: begin
                o_cmd.div_sel   = DIV_SPEED;
                o_cmd.div_start = 1'b1;
                n_state         = S_SPD_WAIT;
            end
            S_SPD_WAIT: begin
                o_cmd.div_sel = DIV_SPEED;
                if (i_sts.div_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // The quotient is held until the result register has room.
                o_cmd.div_sel = DIV_SPEED;
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef NO_ASSERTIONS
    a_start_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |-> !i_sts.div_busy)
        else $error("divider started while busy");
    a_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.div_done |-> (r_state == S_AVG_WAIT || r_state == S_SPD_WAIT))
        else $error("divider finished outside a wait state");
    a_idle_divider: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> !i_sts.div_busy)
        else $error("request accepted while a division runs");
    a_out_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_sts.out_free)
        else $error("result loaded over an untaken result");
`endif

endmodule

[hw/rtl/encoder_period_speed_meter.sv]
// ---------------------------------------------------------------------------
// Encoder period speed meter
// Gathers encoder pulse periods in two banks and reports a filtered speed.
// ---------------------------------------------------------------------------
// Requests arrive on the s-channel: tuser carries the request kind (capture,
// read, swap, clear) and tdata the pulse period used by a capture. Capture,
// swap and clear complete in the cycle they are taken and give no result, so
// they can follow one another every cycle while no read is in work.
// A read request gives one result on the m-channel. Once it is taken, a
// 40-step restoring divider forms the bank average, three multiplies on a
// 16 by 32 bit multiplier run the smoothing filter, and the same divider
// forms the speed. No request is taken while a read is in work.
// The result sits in an output register; further requests are taken while it
// waits. A stalled receiver only holds up the end of the next read.
// Configuration writes (filter enable, coefficient, rpm scale) are taken at
// any time on the cfg channel and should be made while the block is idle.
// Reset empties both banks, selects bank 0, zeroes the filter state and loads
// the register defaults; the block is ready in the next cycle.
// ---------------------------------------------------------------------------
module encoder_period_speed_meter
    import epsm_pkg::*;
#(
    parameter int PULSE_SLOTS = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [31:0]           s_tdata,   // [31:0] pulse_period
    input  logic [1:0]            s_tuser,   // [1:0] req_type
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_W-1:0]      m_tdata,   // [39:0] speed_rpm_q8, [71:40] filtered_count,
                                             // [103:72] average_count
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd w_cmd;
    t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    epsm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    epsm_datapath #(
        .PULSE_SLOTS (PULSE_SLOTS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_s_tuser   (s_tuser),
        .i_s_tdata   (s_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata)
    );

endmodule
